// File: rtl/core/tpiq_pkg.sv
// Shared types and constants of the tide phasor to in-phase/quadrature unit.
package tpiq_pkg;

  localparam int AMP_W  = 24;
  localparam int GAIN_W = 32;
  localparam int OUT_W  = 41;
  localparam int XW     = 33;
  localparam int ZW     = 33;
  localparam int TURN_W = 32;
  localparam int AG_W   = AMP_W + GAIN_W;
  localparam int MW     = 32;
  localparam int FRAC   = 30;
  localparam int OUT_SHIFT = 46;
  localparam int SCALE_STAGES = 6;
  localparam int ATAN_DEPTH = 24;

  localparam logic [AMP_W-1:0]  FILL_RESET   = 24'hFFFFFF;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 32'd497470000;
  localparam logic signed [XW-1:0] CORDIC_START = 33'sd652032874;

  localparam logic REG_FILL_CODE = 1'b0;
  localparam logic REG_GAIN      = 1'b1;

  // atan(2^-i) in units of 2^32 per turn.
  localparam logic [TURN_W-1:0] ATAN_TURN [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic                  valid;
    logic                  fill;
    logic                  flip_p;
    logic                  flip_l;
    logic [AMP_W-1:0]      amp;
    logic signed [XW-1:0]  xp;
    logic signed [XW-1:0]  yp;
    logic signed [ZW-1:0]  zp;
    logic signed [XW-1:0]  xl;
    logic signed [XW-1:0]  yl;
    logic signed [ZW-1:0]  zl;
  } cell_t;

endpackage

// File: rtl/core/tide_phasor_to_inphase_quadrature_unit.sv
// Top level of the tide phasor to in-phase/quadrature unit.
//
//  channel   ports                                         direction  handshake
//  item in   amplitude, phase_angle, latitude              in         start & !busy
//  result    in_phase_part, quadrature_part                out        done, one cycle
//  config    psel, penable, pwrite, paddr, pwdata, prdata  in/out     APB, pready high
//
// One item is accepted every cycle; busy is high only during reset.
// The pipeline holds one CORDIC cell per iteration, one stage that applies the half-turn
// sign and forms amplitude times gain, and six stages of the weighting multiplier
// pipeline.
// Reset clears the valid bits of the whole pipeline and loads the register defaults.
// The receiver cannot stall: each result appears for exactly one cycle with done.
module tide_phasor_to_inphase_quadrature_unit #(
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [tpiq_pkg::AMP_W-1:0]         amplitude,
  input  logic [ANGLE_BITS-1:0]              phase_angle,
  input  logic signed [ANGLE_BITS-1:0]       latitude,
  output logic                               done,
  output logic signed [tpiq_pkg::OUT_W-1:0]  in_phase_part,
  output logic signed [tpiq_pkg::OUT_W-1:0]  quadrature_part,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int LATENCY = TRIG_ITERATIONS + 1 + tpiq_pkg::SCALE_STAGES;
  localparam int PAD_W   = tpiq_pkg::TURN_W - ANGLE_BITS;

  logic [tpiq_pkg::AMP_W-1:0]  fill_code;
  logic [tpiq_pkg::GAIN_W-1:0] gain;
  logic                        cfg_write;
  logic                        accept;
  logic [tpiq_pkg::TURN_W-1:0] turn_p, turn_l;

  tpiq_pkg::cell_t chain [TRIG_ITERATIONS+1];

  logic                           valid_s1;
  logic signed [tpiq_pkg::XW-1:0] cos_p, sin_p, cos_l;
  logic [tpiq_pkg::AG_W-1:0]      ag;
  logic                           zero_s1;
  logic [tpiq_pkg::SCALE_STAGES-1:0] valid_pipe;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_code <= tpiq_pkg::FILL_RESET;
      gain      <= tpiq_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        tpiq_pkg::REG_FILL_CODE: fill_code <= pwdata[tpiq_pkg::AMP_W-1:0];
        tpiq_pkg::REG_GAIN:      gain <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tpiq_pkg::REG_FILL_CODE: prdata = 32'(fill_code);
      tpiq_pkg::REG_GAIN:      prdata = gain;
      default:                 prdata = '0;
    endcase
  end

  assign busy   = rst;
  assign accept = start && !busy;

  // Angles become 32-bit turns; the second and third quadrants are folded by a
  // half turn, which leaves bit 30 as the sign of the residual angle.
  assign turn_p = {phase_angle, {PAD_W{1'b0}}};
  assign turn_l = {latitude, {PAD_W{1'b0}}};

  always_comb begin
    chain[0].valid  = accept;
    chain[0].fill   = (amplitude == fill_code);
    chain[0].flip_p = turn_p[31] ^ turn_p[30];
    chain[0].flip_l = turn_l[31] ^ turn_l[30];
    chain[0].amp    = amplitude;
    chain[0].xp     = tpiq_pkg::CORDIC_START;
    chain[0].yp     = '0;
    chain[0].zp     = {{(tpiq_pkg::ZW-31){turn_p[30]}}, turn_p[30:0]};
    chain[0].xl     = tpiq_pkg::CORDIC_START;
    chain[0].yl     = '0;
    chain[0].zl     = {{(tpiq_pkg::ZW-31){turn_l[30]}}, turn_l[30:0]};
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cell
    tpiq_cordic_cell #(
      .SHIFT(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_in (chain[i]),
      .cell_out(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1   <= 1'b0;
      valid_pipe <= '0;
    end else begin
      valid_s1   <= chain[TRIG_ITERATIONS].valid;
      valid_pipe <= {valid_pipe[tpiq_pkg::SCALE_STAGES-2:0], valid_s1};
    end
  end

  always_ff @(posedge clk) begin
    cos_p   <= chain[TRIG_ITERATIONS].flip_p ? -chain[TRIG_ITERATIONS].xp
                                             : chain[TRIG_ITERATIONS].xp;
    sin_p   <= chain[TRIG_ITERATIONS].flip_p ? -chain[TRIG_ITERATIONS].yp
                                             : chain[TRIG_ITERATIONS].yp;
    cos_l   <= chain[TRIG_ITERATIONS].flip_l ? -chain[TRIG_ITERATIONS].xl
                                             : chain[TRIG_ITERATIONS].xl;
    ag      <= tpiq_pkg::AG_W'(chain[TRIG_ITERATIONS].amp) * tpiq_pkg::AG_W'(gain);
    zero_s1 <= chain[TRIG_ITERATIONS].fill;
  end

  tpiq_scale u_scale_i (
    .clk    (clk),
    .cp     (cos_p),
    .cl     (cos_l),
    .ag     (ag),
    .zero_in(zero_s1),
    .part   (in_phase_part)
  );

  tpiq_scale u_scale_q (
    .clk    (clk),
    .cp     (sin_p),
    .cl     (cos_l),
    .ag     (ag),
    .zero_in(zero_s1),
    .part   (quadrature_part)
  );

  assign done = valid_pipe[tpiq_pkg::SCALE_STAGES-1];

  // Every result matches an item accepted earlier by the full depth of the pipeline;
  // cycles before time zero count as having accepted nothing.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done == ($past(accept, LATENCY) === 1'b1))
    else $error("result strobe does not follow an accepted item");

  // A fill cell yields zero in both parts.
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(accept && (amplitude == fill_code), LATENCY))
      |-> (in_phase_part == '0 && quadrature_part == '0))
    else $error("fill cell produced a nonzero result");

  // Results never leave the pipeline while reset held it empty.
  a_no_done_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !done)
    else $error("result strobe right after reset");

endmodule

// File: rtl/core/tpiq_cordic_cell.sv
// One CORDIC rotation step for the phase and the latitude vector of an item.
module tpiq_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  tpiq_pkg::cell_t cell_in,
  output tpiq_pkg::cell_t cell_out
);

  localparam logic signed [tpiq_pkg::ZW-1:0] STEP_ANGLE =
    tpiq_pkg::ZW'(tpiq_pkg::ATAN_TURN[SHIFT]);

  logic            valid;
  tpiq_pkg::cell_t data;
  tpiq_pkg::cell_t data_next;

  always_comb begin
    data_next = cell_in;
    // Rotate toward zero residual angle; shifts are arithmetic (floor).
    if (!cell_in.zp[tpiq_pkg::ZW-1]) begin
      data_next.xp = cell_in.xp - (cell_in.yp >>> SHIFT);
      data_next.yp = cell_in.yp + (cell_in.xp >>> SHIFT);
      data_next.zp = cell_in.zp - STEP_ANGLE;
    end else begin
      data_next.xp = cell_in.xp + (cell_in.yp >>> SHIFT);
      data_next.yp = cell_in.yp - (cell_in.xp >>> SHIFT);
      data_next.zp = cell_in.zp + STEP_ANGLE;
    end
    if (!cell_in.zl[tpiq_pkg::ZW-1]) begin
      data_next.xl = cell_in.xl - (cell_in.yl >>> SHIFT);
      data_next.yl = cell_in.yl + (cell_in.xl >>> SHIFT);
      data_next.zl = cell_in.zl - STEP_ANGLE;
    end else begin
      data_next.xl = cell_in.xl + (cell_in.yl >>> SHIFT);
      data_next.yl = cell_in.yl - (cell_in.xl >>> SHIFT);
      data_next.zl = cell_in.zl + STEP_ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  always_comb begin
    cell_out       = data;
    cell_out.valid = valid;
  end

endmodule

// File: rtl/core/tpiq_scale.sv
// Weighting pipeline for one output part: trig product, rounding, gain scaling, saturation.
module tpiq_scale (
  input  logic                               clk,
  input  logic signed [tpiq_pkg::XW-1:0]     cp,
  input  logic signed [tpiq_pkg::XW-1:0]     cl,
  input  logic [tpiq_pkg::AG_W-1:0]          ag,
  input  logic                               zero_in,
  output logic signed [tpiq_pkg::OUT_W-1:0]  part
);

  localparam int PW    = 2 * tpiq_pkg::XW;
  localparam int LO_W  = tpiq_pkg::MW;
  localparam int HI_W  = tpiq_pkg::AG_W - LO_W;
  localparam int P0_W  = LO_W + tpiq_pkg::MW;
  localparam int P1_W  = HI_W + tpiq_pkg::MW;
  localparam int SUM_W = tpiq_pkg::AG_W + tpiq_pkg::MW;
  localparam int RW    = SUM_W - tpiq_pkg::OUT_SHIFT;

  localparam logic signed [PW-1:0] W_HALF = PW'(1) <<< (tpiq_pkg::FRAC - 1);
  localparam logic [SUM_W-1:0] R_HALF = SUM_W'(1) << (tpiq_pkg::OUT_SHIFT - 1);
  localparam logic [RW-1:0] NEG_MAG = RW'(1) << (tpiq_pkg::OUT_W - 1);
  localparam logic [RW-1:0] POS_MAX = NEG_MAG - RW'(1);

  logic signed [PW-1:0]           prod;
  logic [tpiq_pkg::AG_W-1:0]      ag_s2, ag_s3, ag_s4;
  logic                           zero_s2, zero_s3, zero_s4, zero_s5, zero_s6;
  logic signed [tpiq_pkg::XW-1:0] w;
  logic                           neg_s4, neg_s5, neg_s6;
  logic [tpiq_pkg::MW-1:0]        m;
  logic [P0_W-1:0]                p0;
  logic [P1_W-1:0]                p1;
  logic [RW-1:0]                  r;
  logic signed [PW-1:0]           wsum;
  logic [SUM_W-1:0]               rsum;
  logic [RW-1:0]                  rsat;
  logic signed [tpiq_pkg::OUT_W-1:0] part_next;

  always_comb begin
    wsum = prod + W_HALF;
    rsum = {p1, {LO_W{1'b0}}} + SUM_W'(p0) + R_HALF;
  end

  always_comb begin
    if (neg_s6) begin
      rsat      = (r > NEG_MAG) ? NEG_MAG : r;
      part_next = -$signed(rsat[tpiq_pkg::OUT_W-1:0]);
    end else begin
      rsat      = (r > POS_MAX) ? POS_MAX : r;
      part_next = $signed(rsat[tpiq_pkg::OUT_W-1:0]);
    end
    if (zero_s6) begin
      part_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= PW'(cp) * PW'(cl);
    ag_s2   <= ag;
    zero_s2 <= zero_in;

    w       <= tpiq_pkg::XW'(wsum >>> tpiq_pkg::FRAC);
    ag_s3   <= ag_s2;
    zero_s3 <= zero_s2;

    neg_s4  <= w[tpiq_pkg::XW-1];
    m       <= w[tpiq_pkg::XW-1] ? tpiq_pkg::MW'(-w) : tpiq_pkg::MW'(w);
    ag_s4   <= ag_s3;
    zero_s4 <= zero_s3;

    // The 56-bit product of amplitude and gain is split into two partial products.
    p0      <= P0_W'(ag_s4[LO_W-1:0]) * P0_W'(m);
    p1      <= P1_W'(ag_s4[tpiq_pkg::AG_W-1:LO_W]) * P1_W'(m);
    neg_s5  <= neg_s4;
    zero_s5 <= zero_s4;

    r       <= rsum[SUM_W-1:tpiq_pkg::OUT_SHIFT];
    neg_s6  <= neg_s5;
    zero_s6 <= zero_s5;

    part    <= part_next;
  end

endmodule
